// ===== hw/rtl/spstat_pkg.sv =====
// Shared types and constants of the section profiler statistics block.
`timescale 1ns / 1ps

package spstat_pkg;

    localparam int SECT_W      = 4;
    localparam int POINT_NUM_W = 6;
    localparam int DROP_W      = 16;

    localparam logic [31:0]       MIN_NONE = 32'hFFFF_FFFF;
    localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_ENTER        = 3'd0,
        OP_EXIT         = 3'd1,
        OP_START_RUN    = 3'd2,
        OP_CLEAR_STATS  = 3'd3,
        OP_READ_SECTION = 3'd4,
        OP_READ_POINT   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_RECORDED = 2'd1,
        ST_NO_SCOPE     = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

    // One point of the buffer: start time while open, duration once closed.
    typedef struct packed {
        logic [31:0]            start;
        logic [SECT_W-1:0]      sect;
        logic [POINT_NUM_W-1:0] depth;
    } point_info_t;

    typedef struct packed {
        logic [31:0] calls;
        logic [31:0] total;
        logic [31:0] min_time;
        logic [31:0] max_time;
    } sect_stats_t;

    localparam sect_stats_t STATS_CLEAR = '{
        calls:    32'd0,
        total:    32'd0,
        min_time: MIN_NONE,
        max_time: 32'd0
    };

    // Control signals of the section statistics store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } stats_ctrl_t;

endpackage

// ===== hw/rtl/section_profiler_stats.sv =====
// Top level of the section profiler: event execution, point stack and result register.
`timescale 1ns / 1ps

// Usage. Events arrive on the item channel (item_valid / item_stall) with an opcode,
// a section number, a timestamp and a point index. Each transfer produces exactly one
// result on the result channel (result_valid / result_stall), in order.
// An accepted item is held in an input register together with the memory data it
// needs; it executes once the result register can load, and its result is written into
// the result register. A new item is taken every cycle while the receiver does not
// stall: one item per cycle sustained, set by the single pass from the input register
// through one subtract, add and compare to the result register.
// The innermost open point and its parent are kept in registers, and the parent of the
// parent is fetched from the point memory during each exit that closes a point, so nested
// exits also run at one per cycle.
// Reset clears the point count, nesting level and drop counter, and marks every section
// statistics entry as cleared through its valid bit; there is no clearing pass, and the
// block takes items right after reset. Clear stats works the same way.
// When the receiver stalls, the result register holds its value, the item waiting in
// the input register stays there, and item_stall rises until the result is taken.

module section_profiler_stats
    import spstat_pkg::*;
#(
    parameter int POINT_CAPACITY = 64,
    parameter int SECTION_COUNT  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  opcode,
    input  logic [3:0]  section_id,
    input  logic [31:0] timestamp,
    input  logic [5:0]  point_sel,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] duration,
    output logic [3:0]  point_section,
    output logic [5:0]  point_level,
    output logic [5:0]  point_number,
    output logic [5:0]  points_used,
    output logic [31:0] calls,
    output logic [31:0] total_time,
    output logic [31:0] min_time,
    output logic [31:0] max_time
);

    localparam int IW = $clog2(POINT_CAPACITY);
    localparam int SW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
    localparam logic [IW-1:0] LAST_FREE = IW'(POINT_CAPACITY - 1);

    // Input register.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    opcode_t                s1_opcode_reg;
    logic [SECT_W-1:0]      s1_section_reg;
    logic [31:0]            s1_timestamp_reg;
    logic [POINT_NUM_W-1:0] s1_point_sel_reg;

    // Run state.
    logic [IW-1:0]          used_count_reg;
    logic [IW-1:0]          used_count_next;
    logic [IW-1:0]          nesting_reg;
    logic [IW-1:0]          nesting_next;
    logic [DROP_W-1:0]      dropped_reg;
    logic [DROP_W-1:0]      dropped_next;

    // Innermost open point, a copy of its parent, and where the parent view comes from.
    point_info_t            top_info_reg;
    point_info_t            top_info_next;
    logic [IW-1:0]          top_idx_reg;
    logic [IW-1:0]          top_idx_next;
    logic [IW-1:0]          top_parent_reg;
    logic [IW-1:0]          top_parent_next;
    point_info_t            copy_info_reg;
    logic [IW-1:0]          copy_idx_reg;
    logic [IW-1:0]          copy_parent_reg;
    logic                   par_from_copy_reg;
    logic                   par_from_copy_next;
    logic [IW-1:0]          ch_idx_reg;

    point_info_t            par_info;
    logic [IW-1:0]          par_idx;
    logic [IW-1:0]          par_parent;

    // Memory ports.
    logic                   pt_wr_en;
    logic [IW-1:0]          pt_wr_addr;
    point_info_t            pt_wr_info;
    logic [IW-1:0]          pt_wr_parent;
    point_info_t            pt_rd_info;
    logic                   ch_en;
    point_info_t            ch_info;
    logic [IW-1:0]          ch_parent;
    stats_ctrl_t            st_ctrl;
    logic [SW-1:0]          st_rd_addr;
    sect_stats_t            st_rd;
    sect_stats_t            st_upd;

    // Execution decisions.
    logic                   item_accept;
    logic                   s1_go;
    logic                   enter_rec;
    logic                   exit_close;
    logic                   top_in_range;
    logic                   sel_in_range;
    logic                   rd_sect_in_range;
    logic [31:0]            dur;

    // Result register.
    logic                   result_valid_reg;
    logic                   result_valid_next;
    status_t                status_reg;
    status_t                status_next;
    logic [31:0]            duration_reg;
    logic [31:0]            duration_next;
    logic [SECT_W-1:0]      point_section_reg;
    logic [SECT_W-1:0]      point_section_next;
    logic [POINT_NUM_W-1:0] point_level_reg;
    logic [POINT_NUM_W-1:0] point_level_next;
    logic [POINT_NUM_W-1:0] point_number_reg;
    logic [POINT_NUM_W-1:0] point_number_next;
    logic [POINT_NUM_W-1:0] points_used_reg;
    sect_stats_t            stats_out_reg;
    sect_stats_t            stats_out_next;

    // Handshake: the input register drains whenever the result register can load.
    assign s1_go       = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && result_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;

    assign par_info   = par_from_copy_reg ? copy_info_reg   : ch_info;
    assign par_idx    = par_from_copy_reg ? copy_idx_reg    : ch_idx_reg;
    assign par_parent = par_from_copy_reg ? copy_parent_reg : ch_parent;

    assign dur              = s1_timestamp_reg - top_info_reg.start;
    assign top_in_range     = 32'(top_info_reg.sect) < SECTION_COUNT;
    assign rd_sect_in_range = 32'(s1_section_reg) < SECTION_COUNT;
    assign sel_in_range     = 32'(s1_point_sel_reg) < 32'(used_count_reg);

    assign enter_rec  = (s1_opcode_reg == OP_ENTER) && (used_count_reg < LAST_FREE);
    assign exit_close = (s1_opcode_reg == OP_EXIT) && (dropped_reg == '0)
                        && (nesting_reg != '0);

    // Statistics of the closed point after this exit.
    always_comb
    begin
        st_upd.calls    = st_rd.calls + 32'd1;
        st_upd.total    = st_rd.total + dur;
        st_upd.min_time = (dur < st_rd.min_time) ? dur : st_rd.min_time;
        st_upd.max_time = (dur > st_rd.max_time) ? dur : st_rd.max_time;
    end

    // One item: next run state, next innermost point and the result fields.
    always_comb
    begin
        used_count_next    = used_count_reg;
        nesting_next       = nesting_reg;
        dropped_next       = dropped_reg;
        top_info_next      = top_info_reg;
        top_idx_next       = top_idx_reg;
        top_parent_next    = top_parent_reg;
        par_from_copy_next = par_from_copy_reg;
        status_next        = ST_OK;
        duration_next      = '0;
        point_section_next = '0;
        point_level_next   = '0;
        point_number_next  = '0;
        stats_out_next     = '0;

        if (s1_go)
        begin
            unique case (s1_opcode_reg)
                OP_ENTER:
                begin
                    if (enter_rec)
                    begin
                        top_info_next      = '{start: s1_timestamp_reg,
                                               sect:  s1_section_reg,
                                               depth: POINT_NUM_W'(nesting_reg)};
                        top_idx_next       = used_count_reg;
                        top_parent_next    = top_idx_reg;
                        par_from_copy_next = 1'b1;
                        nesting_next       = nesting_reg + 1'b1;
                        used_count_next    = used_count_reg + 1'b1;
                        duration_next      = s1_timestamp_reg;
                        point_section_next = s1_section_reg;
                        point_level_next   = POINT_NUM_W'(nesting_reg);
                        point_number_next  = POINT_NUM_W'(used_count_reg);
                    end
                    else
                    begin
                        if (dropped_reg != DROP_MAX)
                        begin
                            dropped_next = dropped_reg + 1'b1;
                        end
                        status_next        = ST_NOT_RECORDED;
                        point_section_next = s1_section_reg;
                    end
                end
                OP_EXIT:
                begin
                    priority if (dropped_reg != '0)
                    begin
                        dropped_next = dropped_reg - 1'b1;
                        status_next  = ST_NOT_RECORDED;
                    end
                    else if (nesting_reg == '0)
                    begin
                        status_next = ST_NO_SCOPE;
                    end
                    else
                    begin
                        top_info_next      = par_info;
                        top_idx_next       = par_idx;
                        top_parent_next    = par_parent;
                        par_from_copy_next = 1'b0;
                        nesting_next       = nesting_reg - 1'b1;
                        duration_next      = dur;
                        point_section_next = top_info_reg.sect;
                        point_level_next   = top_info_reg.depth;
                        point_number_next  = POINT_NUM_W'(top_idx_reg);
                        if (top_in_range)
                        begin
                            stats_out_next = st_upd;
                        end
                    end
                end
                OP_START_RUN:
                begin
                    used_count_next = '0;
                    nesting_next    = '0;
                    dropped_next    = '0;
                end
                OP_CLEAR_STATS:
                begin
                end
                OP_READ_SECTION:
                begin
                    if (rd_sect_in_range)
                    begin
                        stats_out_next = st_rd;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                OP_READ_POINT:
                begin
                    if (sel_in_range)
                    begin
                        duration_next      = pt_rd_info.start;
                        point_section_next = pt_rd_info.sect;
                        point_level_next   = pt_rd_info.depth;
                        point_number_next  = s1_point_sel_reg;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Point memory: a recorded enter writes the new point, a closing exit writes back its duration.
    assign pt_wr_en     = s1_go && (enter_rec || exit_close);
    assign pt_wr_addr   = enter_rec ? used_count_reg : top_idx_reg;
    assign pt_wr_info   = enter_rec ? top_info_next
                                    : point_info_t'{start: dur,
                                                    sect:  top_info_reg.sect,
                                                    depth: top_info_reg.depth};
    assign pt_wr_parent = enter_rec ? top_idx_reg : top_parent_reg;
    assign ch_en        = s1_go && exit_close;

    spstat_point_store #(
        .POINT_CAPACITY (POINT_CAPACITY)
    ) u_point_store (
        .clk       (clk),
        .wr_en     (pt_wr_en),
        .wr_addr   (pt_wr_addr),
        .wr_info   (pt_wr_info),
        .wr_parent (pt_wr_parent),
        .rd_en     (item_accept),
        .rd_addr   (IW'(point_sel)),
        .rd_info   (pt_rd_info),
        .ch_en     (ch_en),
        .ch_addr   (par_parent),
        .ch_info   (ch_info),
        .ch_parent (ch_parent)
    );

    // An exit reads the statistics of the point that will be innermost when it runs.
    assign st_rd_addr    = (opcode == OP_EXIT) ? SW'(top_info_next.sect) : SW'(section_id);
    assign st_ctrl.rd_en = item_accept;
    assign st_ctrl.wr_en = s1_go && exit_close && top_in_range;
    assign st_ctrl.clear = s1_go && (s1_opcode_reg == OP_CLEAR_STATS);

    spstat_sect_stats #(
        .SECTION_COUNT (SECTION_COUNT)
    ) u_sect_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (st_ctrl),
        .rd_addr (st_rd_addr),
        .wr_addr (SW'(top_info_reg.sect)),
        .wr_data (st_upd),
        .rd_data (st_rd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            used_count_reg    <= '0;
            nesting_reg       <= '0;
            dropped_reg       <= '0;
            par_from_copy_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            used_count_reg    <= used_count_next;
            nesting_reg       <= nesting_next;
            dropped_reg       <= dropped_next;
            par_from_copy_reg <= par_from_copy_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_opcode_reg    <= opcode_t'(opcode);
            s1_section_reg   <= section_id;
            s1_timestamp_reg <= timestamp;
            s1_point_sel_reg <= point_sel;
        end
        if (s1_go && enter_rec)
        begin
            copy_info_reg   <= top_info_reg;
            copy_idx_reg    <= top_idx_reg;
            copy_parent_reg <= top_parent_reg;
        end
        if (ch_en)
        begin
            ch_idx_reg <= par_parent;
        end
        top_info_reg   <= top_info_next;
        top_idx_reg    <= top_idx_next;
        top_parent_reg <= top_parent_next;
        if (s1_go)
        begin
            status_reg        <= status_next;
            duration_reg      <= duration_next;
            point_section_reg <= point_section_next;
            point_level_reg   <= point_level_next;
            point_number_reg  <= point_number_next;
            points_used_reg   <= POINT_NUM_W'(used_count_next);
            stats_out_reg     <= stats_out_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign duration      = duration_reg;
    assign point_section = point_section_reg;
    assign point_level   = point_level_reg;
    assign point_number  = point_number_reg;
    assign points_used   = points_used_reg;
    assign calls         = stats_out_reg.calls;
    assign total_time    = stats_out_reg.total;
    assign min_time      = stats_out_reg.min_time;
    assign max_time      = stats_out_reg.max_time;

    // Open scopes are always a subset of the points recorded in the run.
    a_nesting_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        nesting_reg <= used_count_reg)
        else $error("nesting level exceeds recorded points");

    // Enters are dropped only once the buffer has reached its last free slot.
    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (dropped_reg != '0) |-> (used_count_reg == LAST_FREE))
        else $error("dropped scopes counted while the buffer has room");

    // A result appears only after an item sat in the input register.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s1_valid_reg))
        else $error("result produced without an item");

    // An item that cannot execute is kept in the input register.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> s1_valid_reg)
        else $error("waiting item lost from the input register");

endmodule

// ===== hw/rtl/spstat_point_store.sv =====
// Point buffer memory with one write port, a lookup port and a parent-chain port.
`timescale 1ns / 1ps

module spstat_point_store
    import spstat_pkg::*;
#(
    parameter int POINT_CAPACITY = 64
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(POINT_CAPACITY)-1:0] wr_addr,
    input  point_info_t                       wr_info,
    input  logic [$clog2(POINT_CAPACITY)-1:0] wr_parent,
    input  logic                              rd_en,
    input  logic [$clog2(POINT_CAPACITY)-1:0] rd_addr,
    output point_info_t                       rd_info,
    input  logic                              ch_en,
    input  logic [$clog2(POINT_CAPACITY)-1:0] ch_addr,
    output point_info_t                       ch_info,
    output logic [$clog2(POINT_CAPACITY)-1:0] ch_parent
);

    localparam int IW = $clog2(POINT_CAPACITY);

    point_info_t   info_mem   [POINT_CAPACITY];
    logic [IW-1:0] parent_mem [POINT_CAPACITY];

    point_info_t   rd_info_reg;
    point_info_t   ch_info_reg;
    logic [IW-1:0] ch_parent_reg;

    // Both read ports return the data written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            info_mem[wr_addr]   <= wr_info;
            parent_mem[wr_addr] <= wr_parent;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_info_reg <= wr_info;
            end
            else
            begin
                rd_info_reg <= info_mem[rd_addr];
            end
        end
        if (ch_en)
        begin
            if (wr_en && (wr_addr == ch_addr))
            begin
                ch_info_reg   <= wr_info;
                ch_parent_reg <= wr_parent;
            end
            else
            begin
                ch_info_reg   <= info_mem[ch_addr];
                ch_parent_reg <= parent_mem[ch_addr];
            end
        end
    end

    assign rd_info   = rd_info_reg;
    assign ch_info   = ch_info_reg;
    assign ch_parent = ch_parent_reg;

endmodule

// ===== hw/rtl/spstat_sect_stats.sv =====
// Per-section statistics memory with valid bits for an instant clear.
`timescale 1ns / 1ps

module spstat_sect_stats
    import spstat_pkg::*;
#(
    parameter int SECTION_COUNT = 16
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  stats_ctrl_t                                            ctrl,
    input  logic [((SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1)-1:0] rd_addr,
    input  logic [((SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1)-1:0] wr_addr,
    input  sect_stats_t                                            wr_data,
    output sect_stats_t                                            rd_data
);

    sect_stats_t              stats_mem [SECTION_COUNT];
    logic [SECTION_COUNT-1:0] valid_reg;
    logic [SECTION_COUNT-1:0] valid_next;
    sect_stats_t              rd_data_reg;
    logic                     rd_valid_reg;
    logic                     rd_valid_next;
    logic                     same_addr;

    assign same_addr = ctrl.wr_en && (wr_addr == rd_addr);

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (ctrl.rd_en)
        begin
            if (ctrl.clear)
            begin
                rd_valid_next = 1'b0;
            end
            else if (same_addr)
            begin
                rd_valid_next = 1'b1;
            end
            else
            begin
                rd_valid_next = valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            stats_mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            if (same_addr)
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= stats_mem[rd_addr];
            end
        end
    end

    // An entry not written since reset or the last clear reads as cleared.
    assign rd_data = rd_valid_reg ? rd_data_reg : STATS_CLEAR;

endmodule
